FILE: rtl/sbdc_pkg.sv
// Package for the SSD box decoder: payload types, register indexes and half-precision constants.
`default_nettype none
package sbdc_pkg;

    typedef struct packed {
        logic [15:0] class_label_raw;
        logic [15:0] confidence_raw;
        logic [15:0] x_min_raw;
        logic [15:0] y_min_raw;
        logic [15:0] x_max_raw;
        logic [15:0] y_max_raw;
    } t_sbdc_in;

    typedef struct packed {
        logic        keep;
        logic [11:0] out_x_min;
        logic [11:0] out_y_min;
        logic [11:0] out_x_max;
        logic [11:0] out_y_max;
    } t_sbdc_out;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_MARGIN_LEFT   = 3'd2,
        REG_MARGIN_RIGHT  = 3'd3,
        REG_MARGIN_TOP    = 3'd4,
        REG_MARGIN_BOTTOM = 3'd5
    } t_sbdc_reg;

    localparam logic [11:0] RST_IMAGE_WIDTH   = 12'd1280;
    localparam logic [11:0] RST_IMAGE_HEIGHT  = 12'd960;
    localparam logic [7:0]  RST_MARGIN_LEFT   = 8'd30;
    localparam logic [7:0]  RST_MARGIN_RIGHT  = 8'd30;
    localparam logic [7:0]  RST_MARGIN_TOP    = 8'd20;
    localparam logic [7:0]  RST_MARGIN_BOTTOM = 8'd30;

    localparam logic [14:0] HALF_ONE     = 15'h3C00;
    localparam logic [14:0] HALF_EXP_ALL = 15'h7C00;
    localparam logic [4:0]  SUBNORM_SHIFT = 5'd24;
    localparam logic [4:0]  NORM_SHIFT_BASE = 5'd25;

endpackage
`default_nettype wire

FILE: rtl/ssd_box_decode_clamp.sv
// SSD detection record decoder: validity checks, exact scaling, clamp and margin widening.
//
//  Channel | Direction | Handshake                   | Payload
//  --------+-----------+-----------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_ready     | i_in_data  (t_sbdc_in)
//  out     | output    | o_out_valid / i_out_ready   | o_out_data (t_sbdc_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Four register stages: decode and check, multiply, shift, margin and output register.
// One record per cycle is sustained while the output is not stalled.
// Each stage loads whenever it is empty or the stage after it moves, so bubbles close up
// and a stalled output holds its record while earlier stages keep filling.
// Reset clears the valid bits and loads the register defaults; nothing else needs clearing.
`default_nettype none
module ssd_box_decode_clamp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire sbdc_pkg::t_sbdc_in                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output sbdc_pkg::t_sbdc_out                     o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [sbdc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sbdc_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import sbdc_pkg::*;

    function automatic logic f_in_unit(input logic [15:0] h);
        logic neg;
        neg = h[15] && (h[14:0] != 15'd0);
        return !neg && (h[14:0] < HALF_ONE);
    endfunction

    function automatic logic f_label_ok(input logic [15:0] h);
        logic neg;
        neg = h[15] && (h[14:0] != 15'd0);
        return !neg && (h[14:0] <= HALF_EXP_ALL);
    endfunction

    // Configuration registers.
    logic [11:0] r_width, r_height;
    logic [7:0]  r_m_left, r_m_right, r_m_top, r_m_bottom;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RST_IMAGE_WIDTH;
            r_height   <= RST_IMAGE_HEIGHT;
            r_m_left   <= RST_MARGIN_LEFT;
            r_m_right  <= RST_MARGIN_RIGHT;
            r_m_top    <= RST_MARGIN_TOP;
            r_m_bottom <= RST_MARGIN_BOTTOM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:   r_width    <= i_cfg_data;
                REG_IMAGE_HEIGHT:  r_height   <= i_cfg_data;
                REG_MARGIN_LEFT:   r_m_left   <= i_cfg_data[7:0];
                REG_MARGIN_RIGHT:  r_m_right  <= i_cfg_data[7:0];
                REG_MARGIN_TOP:    r_m_top    <= i_cfg_data[7:0];
                REG_MARGIN_BOTTOM: r_m_bottom <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its content moves on.
    logic w_adv1, w_adv2, w_adv3, w_adv4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign w_adv4     = !r_v4 || i_out_ready;
    assign w_adv3     = !r_v3 || w_adv4;
    assign w_adv2     = !r_v2 || w_adv3;
    assign w_adv1     = !r_v1 || w_adv2;
    assign o_in_ready = w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_in_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
            if (w_adv4) r_v4 <= r_v3;
        end
    end

    // Corner order: x min, y min, x max, y max. Even corners scale by width.
    logic [15:0] w_corner [4];
    assign w_corner[0] = i_in_data.x_min_raw;
    assign w_corner[1] = i_in_data.y_min_raw;
    assign w_corner[2] = i_in_data.x_max_raw;
    assign w_corner[3] = i_in_data.y_max_raw;

    // Stage 1: checks and significand/shift decode.
    logic        n_keep1, r_keep1;
    logic [10:0] n_sig1 [4];
    logic [4:0]  n_sh1 [4];
    logic [10:0] r_sig1 [4];
    logic [4:0]  r_sh1 [4];

    always_comb begin
        n_keep1 = f_label_ok(i_in_data.class_label_raw) && f_in_unit(i_in_data.confidence_raw)
                  && f_in_unit(w_corner[0]) && f_in_unit(w_corner[1])
                  && f_in_unit(w_corner[2]) && f_in_unit(w_corner[3]);
        for (int k = 0; k < 4; k++) begin
            if (w_corner[k][14:10] == 5'd0) begin
                n_sig1[k] = {1'b0, w_corner[k][9:0]};
                n_sh1[k]  = SUBNORM_SHIFT;
            end else begin
                n_sig1[k] = {1'b1, w_corner[k][9:0]};
                n_sh1[k]  = NORM_SHIFT_BASE - w_corner[k][14:10];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_keep1 <= n_keep1;
            for (int k = 0; k < 4; k++) begin
                r_sig1[k] <= n_sig1[k];
                r_sh1[k]  <= n_sh1[k];
            end
        end
    end

    // Stage 2: exact products of significand and image size.
    logic        r_keep2;
    logic [22:0] r_prod2 [4];
    logic [4:0]  r_sh2 [4];

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_keep2 <= r_keep1;
            for (int k = 0; k < 4; k++) begin
                r_prod2[k] <= 23'(r_sig1[k]) * 23'((k % 2 == 0) ? r_width : r_height);
                r_sh2[k]   <= r_sh1[k];
            end
        end
    end

    // Stage 3: truncating shift. For a kept record the result stays below a nonzero size.
    logic        r_keep3;
    logic [22:0] n_shr3 [4];
    logic [11:0] r_pix3 [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_shr3[k] = r_prod2[k] >> r_sh2[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_keep3 <= r_keep2;
            for (int k = 0; k < 4; k++) begin
                r_pix3[k] <= n_shr3[k][11:0];
            end
        end
    end

    // Stage 4: margin widening, only where the moved edge stays inside the image.
    t_sbdc_out n_out, r_out;
    logic [12:0] w_x1_sum, w_y1_sum;

    always_comb begin
        w_x1_sum = {1'b0, r_pix3[2]} + 13'(r_m_right);
        w_y1_sum = {1'b0, r_pix3[3]} + 13'(r_m_bottom);
        n_out = '0;
        if (r_keep3) begin
            n_out.keep      = 1'b1;
            n_out.out_x_min = (r_pix3[0] > 12'(r_m_left)) ? r_pix3[0] - 12'(r_m_left)
                                                          : r_pix3[0];
            n_out.out_y_min = (r_pix3[1] > 12'(r_m_top)) ? r_pix3[1] - 12'(r_m_top)
                                                         : r_pix3[1];
            n_out.out_x_max = (w_x1_sum < {1'b0, r_width}) ? w_x1_sum[11:0] : r_pix3[2];
            n_out.out_y_max = (w_y1_sum < {1'b0, r_height}) ? w_y1_sum[11:0] : r_pix3[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the SSD box decoder against an in-bench predictor.
module tb;
    import sbdc_pkg::*;

    // Indexes beyond the last register; writes to them must have no effect.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 18;
    localparam int REPORT_MAX    = 10;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_sbdc_in             in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 cfg_ready;
    t_sbdc_out            out_data;

    // Bench copy of the register file.
    logic [11:0] img_w      = RST_IMAGE_WIDTH;
    logic [11:0] img_h      = RST_IMAGE_HEIGHT;
    logic [7:0]  mg_left    = RST_MARGIN_LEFT;
    logic [7:0]  mg_right   = RST_MARGIN_RIGHT;
    logic [7:0]  mg_top     = RST_MARGIN_TOP;
    logic [7:0]  mg_bottom  = RST_MARGIN_BOTTOM;

    t_sbdc_out expected_boxes[$];
    int        fail_count = 0;
    bit        no_idle    = 1'b0;

    ssd_box_decode_clamp dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Negative zero passes; anything negative, NaN or at least one fails.
    function automatic bit unit_ok(logic [15:0] h);
        logic [14:0] mag;
        mag = h[14:0];
        if (h[15] && mag != 15'd0) return 1'b0;
        return mag < HALF_ONE;
    endfunction

    function automatic bit label_ok(logic [15:0] h);
        logic [14:0] mag;
        mag = h[14:0];
        if (mag > HALF_EXP_ALL) return 1'b0;
        if (h[15] && mag != 15'd0) return 1'b0;
        return 1'b1;
    endfunction

    // Exact floor(v * size) for a half value already known to lie in [0,1).
    function automatic logic [11:0] to_pixels(logic [15:0] h, logic [11:0] size);
        int unsigned e;
        int unsigned sig;
        int unsigned shift;
        e = h[14:10];
        if (e == 0) begin
            sig   = h[9:0];
            shift = SUBNORM_SHIFT;
        end else begin
            sig   = 1024 + h[9:0];
            shift = NORM_SHIFT_BASE - e;
        end
        return 12'((sig * size) >> shift);
    endfunction

    function automatic t_sbdc_out decode_record(t_sbdc_in r);
        t_sbdc_out   box;
        int unsigned x0;
        int unsigned y0;
        int unsigned x1;
        int unsigned y1;
        box = '0;
        if (!label_ok(r.class_label_raw) || !unit_ok(r.confidence_raw) ||
            !unit_ok(r.x_min_raw) || !unit_ok(r.y_min_raw) ||
            !unit_ok(r.x_max_raw) || !unit_ok(r.y_max_raw))
            return box;
        x0 = to_pixels(r.x_min_raw, img_w);
        y0 = to_pixels(r.y_min_raw, img_h);
        x1 = to_pixels(r.x_max_raw, img_w);
        y1 = to_pixels(r.y_max_raw, img_h);
        if (x0 > mg_left) x0 -= mg_left;
        if (x1 + mg_right < img_w) x1 += mg_right;
        if (y0 > mg_top) y0 -= mg_top;
        if (y1 + mg_bottom < img_h) y1 += mg_bottom;
        box.keep      = 1'b1;
        box.out_x_min = 12'(x0);
        box.out_y_min = 12'(y0);
        box.out_x_max = 12'(x1);
        box.out_y_max = 12'(y1);
        return box;
    endfunction

    function automatic t_sbdc_in rec(logic [15:0] label, logic [15:0] conf, logic [15:0] x0,
                                     logic [15:0] y0, logic [15:0] x1, logic [15:0] y1);
        return {label, conf, x0, y0, x1, y1};
    endfunction

    // Value in [0,1), weighted toward the top of the range, subnormals and signed zero.
    function automatic logic [15:0] rand_unit();
        int pick;
        pick = $urandom_range(15);
        if (pick < 7) return 16'($urandom_range(16'h3BFF));
        if (pick < 11) return 16'($urandom_range(16'h3800, 16'h3BFF));
        if (pick < 14) return 16'($urandom_range(16'h03FF));
        return $urandom_range(1) ? 16'h8000 : 16'h0000;
    endfunction

    function automatic logic [15:0] rand_label();
        logic [14:0] mag;
        mag = 15'($urandom_range(16'h7C00));
        return {(mag == 15'd0) ? 1'($urandom_range(1)) : 1'b0, mag};
    endfunction

    function automatic logic [15:0] bad_half();
        case ($urandom_range(3))
            0: return 16'($urandom_range(16'h3C00, 16'h7FFF));
            1: return {1'b1, 15'($urandom_range(1, 16'h7FFF))};
            2: return 16'($urandom_range(16'h7C01, 16'h7FFF));
            default: return 16'hFC00;
        endcase
    endfunction

    // Mostly well-formed records, some with one field spoiled, some pure noise.
    function automatic t_sbdc_in make_record();
        t_sbdc_in r;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            r = {$urandom, $urandom, $urandom};
            return r;
        end
        r = rec(rand_label(), rand_unit(), rand_unit(), rand_unit(), rand_unit(), rand_unit());
        if (pick < 22) begin
            case ($urandom_range(5))
                0: r.class_label_raw = bad_half();
                1: r.confidence_raw  = bad_half();
                2: r.x_min_raw       = bad_half();
                3: r.y_min_raw       = bad_half();
                4: r.x_max_raw       = bad_half();
                default: r.y_max_raw = bad_half();
            endcase
        end
        return r;
    endfunction

    task automatic send_record(input t_sbdc_in r);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_record(make_record());
    endtask

    // Stop sending, wait for every outstanding box, then wait out SETTLE_CYCLES.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_boxes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves the write valid high; the caller lowers it after the last transfer.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:   img_w     = value;
            REG_IMAGE_HEIGHT:  img_h     = value;
            REG_MARGIN_LEFT:   mg_left   = value[7:0];
            REG_MARGIN_RIGHT:  mg_right  = value[7:0];
            REG_MARGIN_TOP:    mg_top    = value[7:0];
            REG_MARGIN_BOTTOM: mg_bottom = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [11:0] w, input logic [11:0] h,
                                input logic [11:0] ml, input logic [11:0] mr,
                                input logic [11:0] mt, input logic [11:0] mb);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_MARGIN_LEFT, ml);
        write_reg(REG_MARGIN_RIGHT, mr);
        write_reg(REG_MARGIN_TOP, mt);
        write_reg(REG_MARGIN_BOTTOM, mb);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_special_values();
        send_record(rec(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_record(rec(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_record(rec(16'h7BFF, 16'h3BFF, 16'h3BFF, 16'h3BFF, 16'h3BFF, 16'h3BFF));
        send_record(rec(16'h3C00, 16'h3C00, 16'h1000, 16'h1000, 16'h3000, 16'h3000));
        send_record(rec(16'h4000, 16'h3800, 16'h3C00, 16'h1000, 16'h3000, 16'h3000));
        send_record(rec(16'h4000, 16'h3800, 16'h1000, 16'h1000, 16'h3000, 16'h3C00));
        send_record(rec(16'h7C00, 16'h3A00, 16'h2000, 16'h2400, 16'h3900, 16'h3A00));
        send_record(rec(16'hFC00, 16'h3A00, 16'h2000, 16'h2400, 16'h3900, 16'h3A00));
        send_record(rec(16'h4200, 16'hFC00, 16'h2000, 16'h2400, 16'h3900, 16'h3A00));
        send_record(rec(16'h4200, 16'h7C00, 16'h2000, 16'h2400, 16'h3900, 16'h3A00));
        send_record(rec(16'h7E00, 16'h3A00, 16'h2000, 16'h2400, 16'h3900, 16'h3A00));
        send_record(rec(16'hFFFF, 16'h3A00, 16'h2000, 16'h2400, 16'h3900, 16'h3A00));
        send_record(rec(16'h4200, 16'h3A00, 16'h2000, 16'h2400, 16'h7C01, 16'h3A00));
        send_record(rec(16'h4200, 16'h3A00, 16'h2000, 16'hFE00, 16'h3900, 16'h3A00));
        send_record(rec(16'hBC00, 16'h3A00, 16'h2000, 16'h2400, 16'h3900, 16'h3A00));
        send_record(rec(16'h4200, 16'h3A00, 16'h8001, 16'h2400, 16'h3900, 16'h3A00));
        send_record(rec(16'h4200, 16'h3A00, 16'h0001, 16'h03FF, 16'h0400, 16'h3800));
        send_record(rec(16'h8000, 16'h0001, 16'h3BFF, 16'h0001, 16'h03FF, 16'h3BFF));
        // Left edge lands exactly on the margin and the right edge exactly one
        // margin short of the width, so neither edge moves.
        send_record(rec(16'h4200, 16'h3A00, 16'h2600, 16'h2600, 16'h3BD0, 16'h3BD0));
        send_record(rec(16'h3C00, 16'h3BFF, 16'h3A00, 16'h3400, 16'h3BD1, 16'h3BFF));
    endtask

    task automatic test_reset_config();
        send_random(150);
        settle();
        send_random(150);
    endtask

    task automatic test_largest_image();
        apply_config(12'd4095, 12'd4095, 12'd255, 12'd255, 12'd255, 12'd255);
        no_idle = 1'b1;
        send_random(300);
        no_idle = 1'b0;
    endtask

    task automatic test_smallest_image();
        apply_config(12'd1, 12'd1, 12'd0, 12'd0, 12'd0, 12'd0);
        send_random(200);
    endtask

    task automatic test_zero_size();
        apply_config(12'd0, 12'd0, 12'd17, 12'd200, 12'd3, 12'd90);
        send_random(150);
    endtask

    // Margin writes carry bits above the register width; spare indexes are ignored.
    task automatic test_masked_writes();
        settle();
        write_reg(REG_SPARE_LO, 12'hFFF);
        write_reg(REG_SPARE_HI, 12'h001);
        cfg_valid <= 1'b0;
        apply_config(12'd640, 12'd480, 12'hA37, 12'hF00, 12'h5FF, 12'h3C4);
        send_random(200);
    endtask

    task automatic test_random_config();
        for (int n = 0; n < 4; n++) begin
            apply_config(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                         12'($urandom_range(255)), 12'($urandom_range(255)),
                         12'($urandom_range(255)), 12'($urandom_range(255)));
            send_random(175);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            expected_boxes.insert(expected_boxes.size(), decode_record(in_data));
    end

    always @(posedge clk) begin : check_results
        t_sbdc_out want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_boxes.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result transfer: keep=%0d box=(%0d,%0d,%0d,%0d)",
                             out_data.keep, out_data.out_x_min, out_data.out_y_min,
                             out_data.out_x_max, out_data.out_y_max);
            end else begin
                want = expected_boxes.pop_front();
                if (want.keep != out_data.keep || want.out_x_min != out_data.out_x_min ||
                    want.out_y_min != out_data.out_y_min ||
                    want.out_x_max != out_data.out_x_max ||
                    want.out_y_max != out_data.out_y_max) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch: expected keep=%0d box=(%0d,%0d,%0d,%0d), %s%0d %s",
                                 want.keep, want.out_x_min, want.out_y_min, want.out_x_max,
                                 want.out_y_max, "got keep=", out_data.keep,
                                 $sformatf("box=(%0d,%0d,%0d,%0d)", out_data.out_x_min,
                                           out_data.out_y_min, out_data.out_x_max,
                                           out_data.out_y_max));
                end
            end
        end
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_values();
        test_reset_config();
        test_largest_image();
        test_smallest_image();
        test_zero_size();
        test_masked_writes();
        test_random_config();
        settle();
        if (fail_count == 0 && expected_boxes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
